### rtl/core/assert_macros.svh
// assertion macros shared by the core rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define NM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define NM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/nm2d_pkg.sv
`timescale 1ns / 1ps
package nm2d_pkg;

  localparam int unsigned CW   = 24;
  localparam int unsigned FB   = 16;
  localparam int unsigned VW   = 48;
  localparam int unsigned IW   = 16;
  localparam int unsigned TW   = 24;
  localparam int unsigned LIMW = TW + 2;

  localparam logic REG_TOL   = 1'b0;
  localparam logic REG_LIMIT = 1'b1;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [VW-1:0] value_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    value_t v;
  } vtx_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LOAD,
    ST_LOAD_DONE,
    ST_EVAL,
    ST_SORT,
    ST_SP_ABS,
    ST_SP_SQ,
    ST_LOOP,
    ST_IT_M,
    ST_IT_R,
    ST_IT_DEC,
    ST_IT_E,
    ST_IT_CI,
    ST_IT_CO,
    ST_IT_S,
    ST_OUT
  } state_e;

  // saturate a widened coordinate
  function automatic coord_t sat_coord(input logic signed [CW+1:0] v);
    logic signed [CW+1:0] hi;
    logic signed [CW+1:0] lo;
    hi = (CW+2)'({1'b0, {(CW-1){1'b1}}});
    lo = -hi - (CW+2)'(1);
    if (v > hi) return hi[CW-1:0];
    else if (v < lo) return lo[CW-1:0];
    else return v[CW-1:0];
  endfunction

  // midpoint rounded toward minus infinity
  function automatic coord_t mid(input coord_t a, input coord_t b);
    logic signed [CW:0] s;
    s = (CW+1)'(a) + (CW+1)'(b);
    s = s >>> 1;
    return s[CW-1:0];
  endfunction

  // 2a - b with saturation
  function automatic coord_t refl(input coord_t a, input coord_t b);
    logic signed [CW+1:0] s;
    s = ((CW+2)'(a) <<< 1) - (CW+2)'(b);
    return sat_coord(s);
  endfunction

endpackage

### rtl/core/nm2d_if.sv
`timescale 1ns / 1ps
interface nm2d_in_if;
  logic              valid;
  logic              ready;
  nm2d_pkg::coord_t  vertex0_x;
  nm2d_pkg::coord_t  vertex0_y;
  nm2d_pkg::coord_t  vertex1_x;
  nm2d_pkg::coord_t  vertex1_y;
  nm2d_pkg::coord_t  vertex2_x;
  nm2d_pkg::coord_t  vertex2_y;

  modport source (output valid, vertex0_x, vertex0_y, vertex1_x, vertex1_y,
                  vertex2_x, vertex2_y, input ready);
  modport sink (input valid, vertex0_x, vertex0_y, vertex1_x, vertex1_y,
                vertex2_x, vertex2_y, output ready);
endinterface

interface nm2d_out_if;
  logic                        valid;
  logic                        ready;
  nm2d_pkg::coord_t            best_x;
  nm2d_pkg::coord_t            best_y;
  nm2d_pkg::value_t            best_value;
  logic [nm2d_pkg::IW-1:0]     iterations_used;
  logic                        converged;

  modport source (output valid, best_x, best_y, best_value, iterations_used,
                  converged, input ready);
  modport sink (input valid, best_x, best_y, best_value, iterations_used,
                converged, output ready);
endinterface

### rtl/core/nm2d_obj.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// objective x^2 - xy + y^2 - 4x - y + 8 on one shared multiplier
module nm2d_obj (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  nm2d_pkg::coord_t x_i,
  input  nm2d_pkg::coord_t y_i,
  output logic             done_o,
  output nm2d_pkg::value_t value_o
);

  localparam int unsigned PW = 2 * nm2d_pkg::CW;
  localparam int unsigned AW = PW + 2;
  localparam int unsigned RW = AW + 2;

  logic                         busy_q;
  logic [2:0]                   step_q;
  logic                         done_q;
  nm2d_pkg::coord_t             x_q, y_q;
  logic signed [PW-1:0]         prod_q;
  logic signed [AW-1:0]         acc_q;
  nm2d_pkg::value_t             value_q;
  nm2d_pkg::coord_t             op_a, op_b;
  logic signed [RW-1:0]         quad, lin, res;
  logic signed [RW-1:0]         vmax, vmin;

  // operand select per step
  always_comb begin
    op_a = (step_q == 3'd2) ? y_q : x_q;
    op_b = (step_q == 3'd0) ? x_q : y_q;
  end

  // final rounding, linear terms and saturation
  always_comb begin
    quad = (RW'(acc_q) + RW'(1 << (nm2d_pkg::FB - 1))) >>> nm2d_pkg::FB;
    lin  = -(RW'(x_q) <<< 2) - RW'(y_q) + (RW'(8) <<< nm2d_pkg::FB);
    res  = quad + lin;
    vmax = RW'({1'b0, {(nm2d_pkg::VW-1){1'b1}}});
    vmin = -vmax - RW'(1);
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 3'd1;
        if (step_q == 3'd4) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      x_q <= x_i;
      y_q <= y_i;
    end else if (busy_q) begin
      prod_q <= op_a * op_b;
      case (step_q)
        3'd1:    acc_q <= AW'(prod_q);
        3'd2:    acc_q <= acc_q - AW'(prod_q);
        3'd3:    acc_q <= acc_q + AW'(prod_q);
        3'd4: begin
          if (res > vmax) value_q <= vmax[nm2d_pkg::VW-1:0];
          else if (res < vmin) value_q <= vmin[nm2d_pkg::VW-1:0];
          else value_q <= res[nm2d_pkg::VW-1:0];
        end
        default: ;
      endcase
    end
  end

  assign done_o  = done_q;
  assign value_o = value_q;

  `NM_ASSERT_NXT(a_done_once, clk_i, rst_ni, done_q, !done_q, "done held twice")
  `NM_ASSERT_IMP(a_done_idle, clk_i, rst_ni, done_q, !busy_q, "done while busy")
  `NM_ASSERT_NXT(a_start_busy, clk_i, rst_ni, start_i && !busy_q, busy_q && !done_q,
                 "start not taken")

endmodule

### rtl/core/nelder_mead_2d_minimizer.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// nelder-mead minimizer of x^2-4x+y^2-y-xy+8 over a 2-d simplex
// in_ch carries three start vertices (Q8.16); one transaction on out_ch
// returns the best vertex, its value (Q32.16), the iteration count and a
// converged flag. config writes (cfg_we_i, cfg_index_i, cfg_data_i) set
// tolerance (index 0) and iteration limit (index 1); the user must issue
// them only while idle, since the block does not enforce it. one item is
// processed at a time; in_ch.ready is high only when idle. every objective
// evaluation goes through one shared multiplier unit. start-up takes 3
// evaluations, a 3-step sort and a spread test; each iteration takes 2 to 5
// evaluations, an optional 3-step sort and a spread test, whose squared sum
// is skipped when a difference is already too large. the iteration count
// is bounded by the limit.
// reset clears the sequencer and sets tolerance 1 and limit 1000.
// a finished result is held on out_ch until the receiver takes it; a stall
// there simply delays the next accepted transaction.
module nelder_mead_2d_minimizer (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic                    cfg_index_i,
  input  logic [nm2d_pkg::TW-1:0] cfg_data_i,
  nm2d_in_if.sink                 in_ch,
  nm2d_out_if.source              out_ch
);

  localparam int unsigned DW  = nm2d_pkg::VW + 1;
  localparam int unsigned SQW = 2 * nm2d_pkg::LIMW;
  localparam int unsigned SAW = SQW + 2;

  nm2d_pkg::state_e state_q, state_d, ret_q, ret_d;

  logic [nm2d_pkg::TW-1:0]   tol_q;
  logic [nm2d_pkg::IW-1:0]   lim_q;
  logic [nm2d_pkg::IW-1:0]   cnt_q;
  logic                      ok_q;
  logic [1:0]                k_q;
  logic [2:0]                sp_q;

  nm2d_pkg::coord_t          in_q [6];
  nm2d_pkg::vtx_t            sx_q [3];
  nm2d_pkg::vtx_t            m_q, r_q, c_q;

  nm2d_pkg::coord_t          ex_q, ey_q;
  logic                      go_q;
  logic                      ev_done;
  nm2d_pkg::value_t          ev_val;
  nm2d_pkg::vtx_t            pt;

  logic                      issue;
  nm2d_pkg::coord_t          iss_x, iss_y;

  logic [nm2d_pkg::LIMW-1:0] lim3;
  logic [DW-1:0]             dabs [3];
  logic                      too_far;
  logic [nm2d_pkg::LIMW-1:0] d_q [3];
  logic [nm2d_pkg::LIMW-1:0] sq_op;
  logic [SQW-1:0]            sq_q;
  logic [SAW-1:0]            sacc_q;

  logic                      acc_r, exp_r;
  nm2d_pkg::vtx_t            cbest;
  logic [1:0]                si;

  // shared objective unit
  nm2d_obj u_obj (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (go_q),
    .x_i     (ex_q),
    .y_i     (ey_q),
    .done_o  (ev_done),
    .value_o (ev_val)
  );

  assign pt = '{x: ex_q, y: ey_q, v: ev_val};

  // decisions of an iteration
  always_comb begin
    acc_r = (sx_q[2].v <= pt.v) && (pt.v < sx_q[1].v);
    exp_r = pt.v < sx_q[2].v;
    cbest = (c_q.v < pt.v) ? c_q : pt;
    si    = (k_q == 2'd1) ? 2'd1 : 2'd0;
  end

  // spread differences
  always_comb begin
    lim3 = nm2d_pkg::LIMW'(tol_q) + (nm2d_pkg::LIMW'(tol_q) << 1);
    dabs[0] = DW'(sx_q[0].v) - DW'(sx_q[1].v);
    dabs[1] = DW'(sx_q[1].v) - DW'(sx_q[2].v);
    dabs[2] = DW'(sx_q[0].v) - DW'(sx_q[2].v);
    for (int i = 0; i < 3; i++) begin
      if (dabs[i][DW-1]) dabs[i] = -dabs[i];
    end
    too_far = (dabs[0] > DW'(lim3)) || (dabs[1] > DW'(lim3)) || (dabs[2] > DW'(lim3));
    case (sp_q)
      3'd0:    sq_op = d_q[0];
      3'd1:    sq_op = d_q[1];
      3'd2:    sq_op = d_q[2];
      default: sq_op = lim3;
    endcase
  end

  // evaluation requests and return points
  always_comb begin
    issue = 1'b0;
    iss_x = ex_q;
    iss_y = ey_q;
    ret_d = ret_q;
    case (state_q)
      nm2d_pkg::ST_LOAD: begin
        issue = 1'b1;
        iss_x = in_q[{k_q, 1'b0}];
        iss_y = in_q[{k_q, 1'b1}];
        ret_d = nm2d_pkg::ST_LOAD_DONE;
      end
      nm2d_pkg::ST_IT_M: begin
        issue = 1'b1;
        iss_x = nm2d_pkg::mid(sx_q[2].x, sx_q[1].x);
        iss_y = nm2d_pkg::mid(sx_q[2].y, sx_q[1].y);
        ret_d = nm2d_pkg::ST_IT_R;
      end
      nm2d_pkg::ST_IT_R: begin
        issue = 1'b1;
        iss_x = nm2d_pkg::refl(pt.x, sx_q[0].x);
        iss_y = nm2d_pkg::refl(pt.y, sx_q[0].y);
        ret_d = nm2d_pkg::ST_IT_DEC;
      end
      nm2d_pkg::ST_IT_DEC: begin
        if (!acc_r) begin
          issue = 1'b1;
          if (exp_r) begin
            iss_x = nm2d_pkg::refl(pt.x, m_q.x);
            iss_y = nm2d_pkg::refl(pt.y, m_q.y);
            ret_d = nm2d_pkg::ST_IT_E;
          end else begin
            iss_x = nm2d_pkg::mid(m_q.x, sx_q[0].x);
            iss_y = nm2d_pkg::mid(m_q.y, sx_q[0].y);
            ret_d = nm2d_pkg::ST_IT_CI;
          end
        end
      end
      nm2d_pkg::ST_IT_CI: begin
        issue = 1'b1;
        iss_x = nm2d_pkg::mid(m_q.x, r_q.x);
        iss_y = nm2d_pkg::mid(m_q.y, r_q.y);
        ret_d = nm2d_pkg::ST_IT_CO;
      end
      nm2d_pkg::ST_IT_CO: begin
        if (!(cbest.v < sx_q[1].v)) begin
          issue = 1'b1;
          iss_x = nm2d_pkg::mid(sx_q[0].x, sx_q[2].x);
          iss_y = nm2d_pkg::mid(sx_q[0].y, sx_q[2].y);
          ret_d = nm2d_pkg::ST_IT_S;
        end
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      nm2d_pkg::ST_IDLE:      if (in_ch.valid) state_d = nm2d_pkg::ST_LOAD;
      nm2d_pkg::ST_LOAD:      state_d = nm2d_pkg::ST_EVAL;
      nm2d_pkg::ST_EVAL:      if (ev_done) state_d = ret_q;
      nm2d_pkg::ST_LOAD_DONE: state_d = (k_q == 2'd2) ? nm2d_pkg::ST_SORT
                                                      : nm2d_pkg::ST_LOAD;
      nm2d_pkg::ST_SORT:      if (k_q == 2'd2) state_d = nm2d_pkg::ST_SP_ABS;
      nm2d_pkg::ST_SP_ABS:    state_d = too_far ? nm2d_pkg::ST_LOOP : nm2d_pkg::ST_SP_SQ;
      nm2d_pkg::ST_SP_SQ:     if (sp_q == 3'd4) state_d = nm2d_pkg::ST_LOOP;
      nm2d_pkg::ST_LOOP:      state_d = (ok_q || cnt_q >= lim_q) ? nm2d_pkg::ST_OUT
                                                                  : nm2d_pkg::ST_IT_M;
      nm2d_pkg::ST_IT_M,
      nm2d_pkg::ST_IT_R,
      nm2d_pkg::ST_IT_CI:     state_d = nm2d_pkg::ST_EVAL;
      nm2d_pkg::ST_IT_DEC:    state_d = acc_r ? nm2d_pkg::ST_SP_ABS : nm2d_pkg::ST_EVAL;
      nm2d_pkg::ST_IT_E,
      nm2d_pkg::ST_IT_S:      state_d = nm2d_pkg::ST_SORT;
      nm2d_pkg::ST_IT_CO:     state_d = issue ? nm2d_pkg::ST_EVAL : nm2d_pkg::ST_SORT;
      nm2d_pkg::ST_OUT:       if (out_ch.ready) state_d = nm2d_pkg::ST_IDLE;
      default:                state_d = nm2d_pkg::ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_ch.ready            = (state_q == nm2d_pkg::ST_IDLE);
    out_ch.valid           = (state_q == nm2d_pkg::ST_OUT);
    out_ch.best_x          = sx_q[2].x;
    out_ch.best_y          = sx_q[2].y;
    out_ch.best_value      = sx_q[2].v;
    out_ch.iterations_used = cnt_q;
    out_ch.converged       = ok_q;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nm2d_pkg::ST_IDLE;
      ret_q   <= nm2d_pkg::ST_IDLE;
      tol_q   <= nm2d_pkg::TW'(1);
      lim_q   <= nm2d_pkg::IW'(1000);
      cnt_q   <= '0;
      ok_q    <= 1'b0;
      k_q     <= '0;
      sp_q    <= '0;
      go_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      go_q    <= issue;
      if (cfg_we_i) begin
        if (cfg_index_i == nm2d_pkg::REG_TOL) tol_q <= cfg_data_i;
        else lim_q <= cfg_data_i[nm2d_pkg::IW-1:0];
      end
      case (state_q)
        nm2d_pkg::ST_IDLE:      begin
          k_q   <= '0;
          cnt_q <= '0;
        end
        nm2d_pkg::ST_LOAD_DONE: k_q <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
        nm2d_pkg::ST_SORT:      k_q <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
        nm2d_pkg::ST_SP_ABS:    begin
          sp_q <= '0;
          if (too_far) ok_q <= 1'b0;
        end
        nm2d_pkg::ST_SP_SQ:     begin
          sp_q <= sp_q + 3'd1;
          if (sp_q == 3'd4) ok_q <= (SAW'(sq_q) >= sacc_q);
        end
        nm2d_pkg::ST_LOOP:      if (state_d == nm2d_pkg::ST_IT_M) begin
          cnt_q <= cnt_q + nm2d_pkg::IW'(1);
        end
        default: ;
      endcase
    end
  end

  // simplex and trial storage
  always_ff @(posedge clk_i) begin
    if (issue) begin
      ex_q <= iss_x;
      ey_q <= iss_y;
    end
    if (in_ch.valid && in_ch.ready) begin
      in_q[0] <= in_ch.vertex0_x;
      in_q[1] <= in_ch.vertex0_y;
      in_q[2] <= in_ch.vertex1_x;
      in_q[3] <= in_ch.vertex1_y;
      in_q[4] <= in_ch.vertex2_x;
      in_q[5] <= in_ch.vertex2_y;
    end
    sq_q <= sq_op * sq_op;
    case (state_q)
      nm2d_pkg::ST_LOAD_DONE: sx_q[k_q] <= pt;
      nm2d_pkg::ST_SORT: begin
        if (sx_q[si].v < sx_q[si + 2'd1].v) begin
          sx_q[si]        <= sx_q[si + 2'd1];
          sx_q[si + 2'd1] <= sx_q[si];
        end
      end
      nm2d_pkg::ST_SP_ABS: begin
        for (int i = 0; i < 3; i++) d_q[i] <= dabs[i][nm2d_pkg::LIMW-1:0];
      end
      nm2d_pkg::ST_SP_SQ: begin
        if (sp_q == 3'd1) sacc_q <= SAW'(sq_q);
        else if (sp_q == 3'd2 || sp_q == 3'd3) sacc_q <= sacc_q + SAW'(sq_q);
      end
      nm2d_pkg::ST_IT_R: m_q <= pt;
      nm2d_pkg::ST_IT_DEC: begin
        r_q <= pt;
        if (acc_r) begin
          sx_q[0] <= sx_q[1];
          sx_q[1] <= pt;
        end
      end
      nm2d_pkg::ST_IT_E: begin
        sx_q[0] <= sx_q[1];
        sx_q[1] <= sx_q[2];
        sx_q[2] <= (pt.v < r_q.v) ? pt : r_q;
      end
      nm2d_pkg::ST_IT_CI: c_q <= pt;
      nm2d_pkg::ST_IT_CO: if (!issue) sx_q[0] <= cbest;
      nm2d_pkg::ST_IT_S: begin
        sx_q[0] <= sx_q[2];
        sx_q[1] <= pt;
        sx_q[2] <= m_q;
      end
      default: ;
    endcase
  end

  `NM_ASSERT_IMP(a_no_overlap, clk_i, rst_ni, out_ch.valid, !in_ch.ready,
                 "input taken while result pending")
  `NM_ASSERT_IMP(a_cnt_bound, clk_i, rst_ni, out_ch.valid && !out_ch.converged,
                 cnt_q == lim_q, "unconverged result before the limit")
  `NM_ASSERT_IMP(a_done_in_eval, clk_i, rst_ni, ev_done,
                 state_q == nm2d_pkg::ST_EVAL, "evaluation finished outside wait")

endmodule

### tb/nelder_mead_2d_minimizer_test.sv
`timescale 1ns / 1ps
module nelder_mead_2d_minimizer_test;

  localparam longint CYCLE_LIMIT = 100000000;

  typedef struct {
    nm2d_pkg::coord_t c [6];
  } problem_t;

  typedef struct {
    nm2d_pkg::coord_t           x;
    nm2d_pkg::coord_t           y;
    nm2d_pkg::value_t           v;
    logic [nm2d_pkg::IW-1:0]    iters;
    logic                       conv;
  } answer_t;

  typedef struct {
    longint x;
    longint y;
    longint v;
  } point_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_index_i;
  logic [nm2d_pkg::TW-1:0] cfg_data_i;

  nm2d_in_if  in_ch ();
  nm2d_out_if out_ch ();

  nelder_mead_2d_minimizer dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  // model copy of the registers
  longint tol_reg;
  longint limit_reg;

  problem_t problem_q [$];
  answer_t  answer_q [$];
  int       mismatches;
  bit       quiet;
  longint   cycles;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint clamp(longint v, int w);
    longint hi;
    hi = (longint'(1) <<< (w - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  // quadratic cost, exact products split into integer and fraction sums
  function automatic point_t make_point(longint xi, longint yi);
    point_t p;
    longint prod [3];
    longint hi;
    longint lo;
    longint r;
    p.x = clamp(xi, nm2d_pkg::CW);
    p.y = clamp(yi, nm2d_pkg::CW);
    prod[0] = p.x * p.x;
    prod[1] = -p.x * p.y;
    prod[2] = p.y * p.y;
    hi = 0;
    lo = 0;
    for (int k = 0; k < 3; k++) begin
      hi += prod[k] >>> nm2d_pkg::FB;
      lo += prod[k] & ((longint'(1) <<< nm2d_pkg::FB) - 1);
    end
    r = hi + ((lo + (longint'(1) <<< (nm2d_pkg::FB - 1))) >>> nm2d_pkg::FB);
    r += -4 * p.x - p.y + (longint'(8) <<< nm2d_pkg::FB);
    p.v = clamp(r, nm2d_pkg::VW);
    return p;
  endfunction

  // worst first, best last; swap only on strict order
  function automatic void order_simplex(ref point_t s [3]);
    point_t t;
    int idx [3] = '{0, 1, 0};
    for (int k = 0; k < 3; k++) begin
      if (s[idx[k]].v < s[idx[k] + 1].v) begin
        t = s[idx[k]];
        s[idx[k]] = s[idx[k] + 1];
        s[idx[k] + 1] = t;
      end
    end
  endfunction

  function automatic bit spread_within(const ref point_t s [3]);
    longint d [3];
    longint lim;
    longint sum;
    lim = 3 * tol_reg;
    sum = 0;
    d[0] = s[0].v - s[1].v;
    d[1] = s[1].v - s[2].v;
    d[2] = s[0].v - s[2].v;
    for (int k = 0; k < 3; k++) begin
      if (d[k] < 0) d[k] = -d[k];
      if (d[k] > lim) return 1'b0;
      sum += d[k] * d[k];
    end
    return sum <= lim * lim;
  endfunction

  function automatic void simplex_step(ref point_t s [3]);
    point_t w, g, b, m, r, e, ci, co, c, sh;
    w = s[0];
    g = s[1];
    b = s[2];
    m = make_point((b.x + g.x) >>> 1, (b.y + g.y) >>> 1);
    r = make_point(2 * m.x - w.x, 2 * m.y - w.y);
    if (b.v <= r.v && r.v < g.v) begin
      s[0] = g;
      s[1] = r;
    end else if (r.v < b.v) begin
      e = make_point(2 * r.x - m.x, 2 * r.y - m.y);
      s[0] = g;
      s[1] = b;
      s[2] = (e.v < r.v) ? e : r;
      order_simplex(s);
    end else begin
      ci = make_point((m.x + w.x) >>> 1, (m.y + w.y) >>> 1);
      co = make_point((m.x + r.x) >>> 1, (m.y + r.y) >>> 1);
      c = (ci.v < co.v) ? ci : co;
      if (c.v < g.v) begin
        s[0] = c;
      end else begin
        sh = make_point((w.x + b.x) >>> 1, (w.y + b.y) >>> 1);
        s[0] = b;
        s[1] = sh;
        s[2] = m;
      end
      order_simplex(s);
    end
  endfunction

  function automatic answer_t minimize(problem_t pr);
    point_t s [3];
    answer_t a;
    longint n;
    bit ok;
    for (int k = 0; k < 3; k++) s[k] = make_point(pr.c[2 * k], pr.c[2 * k + 1]);
    order_simplex(s);
    n = 0;
    ok = spread_within(s);
    while (!ok && n < limit_reg) begin
      n++;
      simplex_step(s);
      ok = spread_within(s);
    end
    a.x = nm2d_pkg::coord_t'(s[2].x);
    a.y = nm2d_pkg::coord_t'(s[2].y);
    a.v = nm2d_pkg::value_t'(s[2].v);
    a.iters = nm2d_pkg::IW'(n);
    a.conv = ok;
    return a;
  endfunction

  // input driver with random idle bursts
  int src_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    logic nxt_valid;
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.vertex0_x <= '0;
      in_ch.vertex0_y <= '0;
      in_ch.vertex1_x <= '0;
      in_ch.vertex1_y <= '0;
      in_ch.vertex2_x <= '0;
      in_ch.vertex2_y <= '0;
      src_gap = 0;
    end else begin
      nxt_valid = in_ch.valid;
      if (in_ch.valid && in_ch.ready) begin
        answer_q.push_back(minimize(problem_q.pop_front()));
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (src_gap > 0) begin
          src_gap--;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
          src_gap = $urandom_range(1, 19);
        end else if (problem_q.size() > 0) begin
          nxt_valid = 1'b1;
          in_ch.vertex0_x <= problem_q[0].c[0];
          in_ch.vertex0_y <= problem_q[0].c[1];
          in_ch.vertex1_x <= problem_q[0].c[2];
          in_ch.vertex1_y <= problem_q[0].c[3];
          in_ch.vertex2_x <= problem_q[0].c[4];
          in_ch.vertex2_y <= problem_q[0].c[5];
        end
      end
      in_ch.valid <= nxt_valid;
    end
  end

  // result monitor with random stalls
  int sink_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    answer_t exp_a;
    logic nxt_ready;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      sink_gap = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (answer_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transaction");
        end else begin
          exp_a = answer_q.pop_front();
          if (out_ch.best_x !== exp_a.x || out_ch.best_y !== exp_a.y ||
              out_ch.best_value !== exp_a.v || out_ch.iterations_used !== exp_a.iters ||
              out_ch.converged !== exp_a.conv) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp x=%0d y=%0d v=%0d it=%0d c=%0b",
                       exp_a.x, exp_a.y, exp_a.v, exp_a.iters, exp_a.conv,
                       " got x=%0d y=%0d v=%0d it=%0d c=%0b",
                       out_ch.best_x, out_ch.best_y, out_ch.best_value,
                       out_ch.iterations_used, out_ch.converged);
          end
        end
      end
      nxt_ready = 1'b1;
      if (sink_gap > 0) begin
        sink_gap--;
        nxt_ready = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        sink_gap = $urandom_range(0, 18);
        nxt_ready = 1'b0;
      end
      out_ch.ready <= nxt_ready;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic add_problem(longint a, longint b, longint c, longint d, longint e,
                             longint f);
    problem_t pr;
    pr.c[0] = nm2d_pkg::coord_t'(a);
    pr.c[1] = nm2d_pkg::coord_t'(b);
    pr.c[2] = nm2d_pkg::coord_t'(c);
    pr.c[3] = nm2d_pkg::coord_t'(d);
    pr.c[4] = nm2d_pkg::coord_t'(e);
    pr.c[5] = nm2d_pkg::coord_t'(f);
    problem_q.push_back(pr);
  endtask

  // mostly near the minimum, sometimes anywhere
  task automatic add_random(int n);
    problem_t pr;
    for (int i = 0; i < n; i++) begin
      for (int k = 0; k < 6; k++) begin
        if ($urandom_range(0, 4) == 0) pr.c[k] = nm2d_pkg::coord_t'($urandom);
        else pr.c[k] = nm2d_pkg::coord_t'($signed($urandom_range(0, 2 * 655360)) - 655360);
      end
      problem_q.push_back(pr);
    end
  endtask

  task automatic drain();
    wait (problem_q.size() == 0 && answer_q.size() == 0);
    repeat (5) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, longint val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= nm2d_pkg::TW'(val);
    if (idx == nm2d_pkg::REG_TOL) tol_reg = val;
    else limit_reg = val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  localparam longint ONE  = 65536;
  localparam longint CMAX = 8388607;
  localparam longint CMIN = -8388608;

  // stimulus and end of run
  initial begin
    mismatches = 0;
    quiet = 1'b0;
    cycles = 0;
    tol_reg = 1;
    limit_reg = 1000;
    cfg_we_i = 1'b0;
    cfg_index_i = nm2d_pkg::REG_TOL;
    cfg_data_i = '0;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: degenerate and near-optimal start simplices
    add_problem(3 * ONE, 2 * ONE, 3 * ONE, 2 * ONE, 3 * ONE, 2 * ONE);
    add_problem(0, 0, ONE, 0, 0, ONE);
    add_problem(0, 0, 0, 0, 0, 0);
    drain();

    // zero limit and zero tolerance: only the sorted start simplex
    write_reg(nm2d_pkg::REG_LIMIT, 0);
    write_reg(nm2d_pkg::REG_TOL, 0);
    add_problem(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN);
    add_problem(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX);
    add_problem(CMAX, CMIN, CMIN, CMAX, 0, 0);
    add_problem(ONE, ONE, -ONE, -ONE, ONE, -ONE);
    add_problem(5 * ONE, 0, 0, 5 * ONE, 5 * ONE, 5 * ONE);
    drain();

    // one iteration, saturating reflections and ties
    write_reg(nm2d_pkg::REG_LIMIT, 1);
    add_problem(CMAX, CMAX, CMAX, CMIN, CMIN, CMAX);
    add_problem(CMIN, CMIN, CMAX, CMAX, CMIN, CMAX);
    add_problem(ONE, 0, -ONE, 0, 0, 4 * ONE);
    add_problem(4 * ONE, ONE, 2 * ONE, 3 * ONE, 3 * ONE, 2 * ONE);
    add_problem(10 * ONE, 10 * ONE, -10 * ONE, 10 * ONE, 0, -10 * ONE);
    add_problem(0, 0, 0, 0, ONE, ONE);
    drain();

    // widest tolerance and longest limit
    write_reg(nm2d_pkg::REG_TOL, 24'hFFFFFF);
    write_reg(nm2d_pkg::REG_LIMIT, 65535);
    add_problem(CMAX, 0, 0, CMAX, CMIN, CMIN);
    add_problem(3 * ONE, 2 * ONE, 7 * ONE, -3 * ONE, -2 * ONE, 6 * ONE);
    add_random(5);
    drain();

    // moderate settings, random problems
    write_reg(nm2d_pkg::REG_TOL, 24'h000800);
    write_reg(nm2d_pkg::REG_LIMIT, 200);
    add_random(50);
    drain();

    // tight settings; the tail runs with no idling
    write_reg(nm2d_pkg::REG_TOL, 24'h000100);
    write_reg(nm2d_pkg::REG_LIMIT, 40);
    add_random(25);
    wait (problem_q.size() == 0);
    quiet = 1'b1;
    add_random(15);
    drain();

    repeat (50) @(posedge clk_i);
    if (mismatches == 0 && answer_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/nm2d_pkg.sv
rtl/core/nm2d_if.sv
rtl/core/nm2d_obj.sv
rtl/core/nelder_mead_2d_minimizer.sv
tb/nelder_mead_2d_minimizer_test.sv
